### rtl/core/ald_pkg.sv
// Shared constants, types and helper functions of the area-average line downscaler.
package ald_pkg;

  // Line and sample limits.
  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned SAMPLE_BITS = 16;

  // Register port and field widths.
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned IDX_W     = 12;

  // Derived datapath widths.
  localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SUM_W  = $clog2(MAX_WIDTH) + SAMPLE_BITS;
  localparam int unsigned PROD_W = SAMPLE_BITS + WID_W;
  localparam int unsigned NUM_W  = SUM_W + 2;
  localparam int unsigned DEN_W  = WID_W + 1;
  localparam int unsigned STEP_W = $clog2(SAMPLE_BITS);

  // Queue between the accumulator and the divider.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH = CFG_IDX_W'(1);

  // One closed output waiting for its division.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [WID_W-1:0] src;
    logic [IDX_W-1:0] index;
    logic             last;
  } job_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // Saturate a programmed width into the range 1 to MAX_WIDTH.
  function automatic logic [WID_W-1:0] sat_width(input logic [CFG_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v == '0) begin
      r = WID_W'(1);
    end else if (v > CFG_W'(MAX_WIDTH)) begin
      r = WID_W'(MAX_WIDTH);
    end else begin
      r = WID_W'(v);
    end
    return r;
  endfunction

endpackage

### rtl/core/area_average_line_downscaler.sv
// Top level of the area-average line downscaler.
//
// Source samples of a line enter one per clock on the sample channel; each output sample is
// the area-weighted average of the source samples it covers, rounded half up, tagged with its
// position in the line and an end-of-line flag. The front end takes a sample every cycle; a
// sample that closes an output is held off only while the two-word queue in front of the
// divider is full. The divider produces one quotient bit per cycle; each output occupies it
// for a load step and 16 quotient steps, plus any wait while the output register is stalled.
// A write to either width register restarts the line; widths are saturated to 1..4096 and the
// output width is clamped to the input width. The register port is always ready and needs no
// setup time.
module area_average_line_downscaler
  import ald_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   sample_valid_i,
  output logic                   sample_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   pixel_valid_o,
  input  logic                   pixel_stall_i,
  output logic [SAMPLE_BITS-1:0] pixel_value_o,
  output logic [IDX_W-1:0]       out_index_o,
  output logic                   end_of_line_o
);

  logic          push;
  logic          pop;
  job_t          job_in;
  job_t          job_out;
  queue_status_t status;

  // Register writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  ald_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_valid_i (sample_valid_i),
    .sample_i       (sample_i),
    .sample_stall_o (sample_stall_o),
    .push_o         (push),
    .job_o          (job_in),
    .status_i       (status)
  );

  ald_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job_in),
    .pop_i    (pop),
    .job_o    (job_out),
    .status_o (status)
  );

  ald_divider u_divider (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .status_i      (status),
    .job_i         (job_out),
    .pop_o         (pop),
    .pixel_valid_o (pixel_valid_o),
    .pixel_stall_i (pixel_stall_i),
    .pixel_value_o (pixel_value_o),
    .out_index_o   (out_index_o),
    .end_of_line_o (end_of_line_o)
  );

endmodule

### rtl/core/ald_front.sv
// Front end: width registers, coverage tracking and weighted accumulation per output.
module ald_front
  import ald_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 sample_valid_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                 sample_stall_o,
  output logic                 push_o,
  output job_t                 job_o,
  input  queue_status_t        status_i
);

  logic [CFG_W-1:0]  src_q, src_d;
  logic [CFG_W-1:0]  dst_q, dst_d;
  logic [WID_W-1:0]  cov_q, cov_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [IDX_W-1:0]  count_q, count_d;

  logic [WID_W-1:0]  src_eff;
  logic [WID_W-1:0]  dst_sat;
  logic [WID_W-1:0]  dst_eff;
  logic              close;
  logic              accept;
  logic [PROD_W-1:0] prod_dst;
  logic [PROD_W-1:0] prod_cov;
  logic [SUM_W-1:0]  total;
  logic [WID_W-1:0]  rest;
  logic [WID_W-1:0]  count_inc;
  logic              last;

  // Effective widths; the output count never exceeds the input count.
  assign src_eff = sat_width(src_q);
  assign dst_sat = sat_width(dst_q);
  assign dst_eff = (dst_sat > src_eff) ? src_eff : dst_sat;

  // A sample closes the current output when it covers all remaining units.
  assign close          = (dst_eff >= cov_q);
  assign sample_stall_o = close && status_i.full;
  assign accept         = sample_valid_i && !sample_stall_o;

  // Weighted contributions of the sample.
  assign prod_dst  = PROD_W'(sample_i) * PROD_W'(dst_eff);
  assign prod_cov  = PROD_W'(sample_i) * PROD_W'(cov_q);
  assign total     = sum_q + SUM_W'(prod_cov);
  assign rest      = dst_eff - cov_q;
  assign count_inc = WID_W'(count_q) + WID_W'(1);
  assign last      = (count_inc >= dst_eff);

  // Closed output handed to the divider.
  assign push_o      = accept && close;
  assign job_o.sum   = total;
  assign job_o.src   = src_eff;
  assign job_o.index = count_q;
  assign job_o.last  = last;

  // Register writes and line state update.
  always_comb begin
    src_d   = src_q;
    dst_d   = dst_q;
    cov_d   = cov_q;
    sum_d   = sum_q;
    count_d = count_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == REG_SRC_WIDTH) begin
        src_d = cfg_data_i;
      end
      if (cfg_index_i == REG_DST_WIDTH) begin
        dst_d = cfg_data_i;
      end
      if (cfg_index_i == REG_SRC_WIDTH || cfg_index_i == REG_DST_WIDTH) begin
        cov_d   = sat_width(src_d);
        sum_d   = '0;
        count_d = '0;
      end
    end else if (accept) begin
      if (!close) begin
        sum_d = sum_q + SUM_W'(prod_dst);
        cov_d = cov_q - dst_eff;
      end else if (last) begin
        cov_d   = src_eff;
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = SUM_W'(prod_dst - prod_cov);
        cov_d   = src_eff - rest;
        count_d = count_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= CFG_W'(1);
      dst_q   <= CFG_W'(1);
      cov_q   <= WID_W'(1);
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      src_q   <= src_d;
      dst_q   <= dst_d;
      cov_q   <= cov_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

### rtl/core/ald_queue.sv
// Short queue of closed outputs between the accumulator and the divider.
module ald_queue
  import ald_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  job_t          job_i,
  input  logic          pop_i,
  output job_t          job_o,
  output queue_status_t status_o
);

  job_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign job_o          = entries_q[rd_ptr_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !status_o.full)
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !status_o.empty)
    else $error("queue read while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      push_i && !pop_i |=> !status_o.empty)
    else $error("queue lost a word");
`endif

endmodule

### rtl/core/ald_divider.sv
// Back end: serial rounding divider and the registered output word.
module ald_divider
  import ald_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  queue_status_t          status_i,
  input  job_t                   job_i,
  output logic                   pop_o,
  output logic                   pixel_valid_o,
  input  logic                   pixel_stall_i,
  output logic [SAMPLE_BITS-1:0] pixel_value_o,
  output logic [IDX_W-1:0]       out_index_o,
  output logic                   end_of_line_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } div_state_e;

  div_state_e             state_q, state_d;
  logic [NUM_W-1:0]       rem_q, rem_d;
  logic [DEN_W-1:0]       den_q, den_d;
  logic [SAMPLE_BITS-1:0] quo_q, quo_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   last_q, last_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_value_q, out_value_d;
  logic [IDX_W-1:0]       out_index_q, out_index_d;
  logic                   out_last_q, out_last_d;

  logic                   out_free;
  logic                   load_out;
  logic [NUM_W-1:0]       trial;
  logic                   fits;
  logic [SAMPLE_BITS-1:0] quo_step;

  // The output register can take a word when empty or being drained.
  assign out_free = !out_valid_q || !pixel_stall_i;

  // One restoring quotient bit per cycle, most significant first.
  assign trial = NUM_W'(den_q) << step_q;
  assign fits  = (rem_q >= trial);
  always_comb begin
    quo_step = quo_q;
    if (fits) begin
      quo_step[step_q] = 1'b1;
    end
  end

  // Sequencer: load a job, run the quotient steps, hand the result over.
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    step_d      = step_q;
    idx_d       = idx_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    load_out    = 1'b0;
    out_value_d = out_value_q;
    case (state_q)
      ST_IDLE: begin
        if (!status_i.empty) begin
          pop_o   = 1'b1;
          // Rounding half up: (2*sum + S) / (2*S).
          rem_d   = NUM_W'({job_i.sum, 1'b0}) + NUM_W'(job_i.src);
          den_d   = {job_i.src, 1'b0};
          quo_d   = '0;
          step_d  = STEP_W'(SAMPLE_BITS - 1);
          idx_d   = job_i.index;
          last_d  = job_i.last;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (fits) begin
          rem_d = rem_q - trial;
        end
        quo_d = quo_step;
        if (step_q == '0) begin
          if (out_free) begin
            load_out    = 1'b1;
            out_value_d = quo_step;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_value_d = quo_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output word register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_index_d = out_index_q;
    out_last_d  = out_last_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_index_d = idx_q;
      out_last_d  = last_q;
    end else if (out_valid_q && !pixel_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    den_q       <= den_d;
    quo_q       <= quo_d;
    step_q      <= step_d;
    idx_q       <= idx_d;
    last_q      <= last_d;
    out_value_q <= out_value_d;
    out_index_q <= out_index_d;
    out_last_q  <= out_last_d;
  end

  assign pixel_valid_o = out_valid_q;
  assign pixel_value_o = out_value_q;
  assign out_index_o   = out_index_q;
  assign end_of_line_o = out_last_q;

endmodule
